// ----- src/flow_bulk_transfer_detector_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the fbtd_engine module of the bulk transfer detector RTL.
// Each macro checks on the rising edge of i_clk and is off during reset.
// ---------------------------------------------------------------------------
`ifndef FLOW_BULK_TRANSFER_DETECTOR_DEFINES_SVH
`define FLOW_BULK_TRANSFER_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBTD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fbtd_pkg.sv -----
// ---------------------------------------------------------------------------
// fbtd_pkg
// Shared types and constants of the bulk transfer detector.
// ---------------------------------------------------------------------------
package fbtd_pkg;

    localparam int DEF_TIME_WIDTH  = 48;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int BYTE_WIDTH      = 48;
    localparam int LEN_WIDTH       = 16;
    localparam int GAP_WIDTH       = 32;
    localparam int MINP_WIDTH      = 8;
    localparam int CFG_IDX_WIDTH   = 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [GAP_WIDTH-1:0]  GAP_RESET  = 32'd1000000;
    localparam logic [MINP_WIDTH-1:0] MINP_RESET = 8'd4;
    localparam logic [MINP_WIDTH-1:0] MINP_FLOOR = 8'd2;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_BULK_GAP = 1'b0,
        REG_BULK_MIN = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [GAP_WIDTH-1:0]  bulk_gap_us;
        logic [MINP_WIDTH-1:0] bulk_min_packets;
    } t_cfg;

endpackage

// ----- src/fbtd_front.sv -----
// ---------------------------------------------------------------------------
// fbtd_front
// Input queue: takes packet items, tags clear and empty items, and holds
// them until the update engine takes them.
// ---------------------------------------------------------------------------
module fbtd_front #(
    parameter int TIME_WIDTH = fbtd_pkg::DEF_TIME_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_opcode,
    input  logic                           i_direction,
    input  logic [TIME_WIDTH-1:0]          i_timestamp_us,
    input  logic [fbtd_pkg::LEN_WIDTH-1:0] i_packet_length,
    output logic                           o_full,
    input  logic                           i_take,
    output logic                           o_valid,
    output logic                           o_clear,
    output logic                           o_empty_pkt,
    output logic                           o_direction,
    output logic [TIME_WIDTH-1:0]          o_timestamp_us,
    output logic [fbtd_pkg::LEN_WIDTH-1:0] o_packet_length
);
    import fbtd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                  r_clear [QUEUE_DEPTH];
    logic                  r_empty [QUEUE_DEPTH];
    logic                  r_dir   [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] r_ts    [QUEUE_DEPTH];
    logic [LEN_WIDTH-1:0]  r_len   [QUEUE_DEPTH];

    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_clear[r_wr_ptr] <= (i_opcode == OP_CLEAR);
            r_empty[r_wr_ptr] <= (i_packet_length == '0);
            r_dir[r_wr_ptr]   <= i_direction;
            r_ts[r_wr_ptr]    <= i_timestamp_us;
            r_len[r_wr_ptr]   <= i_packet_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_clear         = r_clear[r_rd_ptr];
    assign o_empty_pkt     = r_empty[r_rd_ptr];
    assign o_direction     = r_dir[r_rd_ptr];
    assign o_timestamp_us  = r_ts[r_rd_ptr];
    assign o_packet_length = r_len[r_rd_ptr];

endmodule

// ----- src/fbtd_engine.sv -----
// ---------------------------------------------------------------------------
// fbtd_engine
// Per-direction candidate and bulk state; one read-modify-write per item,
// producing the totals after that item.
// ---------------------------------------------------------------------------
`include "flow_bulk_transfer_detector_defines.svh"

module fbtd_engine #(
    parameter int TIME_WIDTH  = fbtd_pkg::DEF_TIME_WIDTH,
    parameter int COUNT_WIDTH = fbtd_pkg::DEF_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fbtd_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    input  logic                            i_clear,
    input  logic                            i_empty_pkt,
    input  logic                            i_direction,
    input  logic [TIME_WIDTH-1:0]           i_timestamp_us,
    input  logic [fbtd_pkg::LEN_WIDTH-1:0]  i_packet_length,
    output logic                            o_take,
    input  logic                            i_out_full,
    output logic                            o_push,
    output logic [COUNT_WIDTH-1:0]          o_res_count    [2],
    output logic [COUNT_WIDTH-1:0]          o_res_packets  [2],
    output logic [fbtd_pkg::BYTE_WIDTH-1:0] o_res_bytes    [2],
    output logic [TIME_WIDTH-1:0]           o_res_time_us  [2],
    output logic                            o_res_in_bulk
);
    import fbtd_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int BW = BYTE_WIDTH;

    logic [TW-1:0] r_start [2];
    logic [TW-1:0] r_last  [2];
    logic [CW-1:0] r_pk    [2];
    logic [BW-1:0] r_by    [2];
    logic [CW-1:0] r_cnt   [2];
    logic [CW-1:0] r_ptot  [2];
    logic [BW-1:0] r_btot  [2];
    logic [TW-1:0] r_ttot  [2];

    logic [TW-1:0] n_start [2];
    logic [TW-1:0] n_last  [2];
    logic [CW-1:0] n_pk    [2];
    logic [BW-1:0] n_by    [2];
    logic [CW-1:0] n_cnt   [2];
    logic [CW-1:0] n_ptot  [2];
    logic [BW-1:0] n_btot  [2];
    logic [TW-1:0] n_ttot  [2];

    logic            fire;
    logic [TW-1:0]   cur_start, cur_last, oth_last, start_eff;
    logic [CW-1:0]   cur_pk, cur_cnt, cur_ptot;
    logic [BW-1:0]   cur_by, cur_btot;
    logic [TW-1:0]   cur_ttot;
    logic            restart;
    logic [TW-1:0]   gap_delta;
    logic [7:0]      minp_c;
    logic [CW-1:0]   minp;
    logic [CW:0]     pk_sum, cnt_sum, ptot_sum;
    logic [BW:0]     by_sum, btot_sum;
    logic [TW:0]     ttot_sum;
    logic [CW-1:0]   pk_new, cnt_new, ptot_new, ptot_add;
    logic [BW-1:0]   by_new, btot_new, btot_add;
    logic [TW-1:0]   ttot_new, t_base, t_delta;
    logic            hit, over, t_pos;

    assign fire   = i_valid && !i_out_full;
    assign o_take = fire;
    assign o_push = fire;

    // Lane select for the item's own direction and the opposite one.
    assign cur_start = i_direction ? r_start[1] : r_start[0];
    assign cur_last  = i_direction ? r_last[1]  : r_last[0];
    assign oth_last  = i_direction ? r_last[0]  : r_last[1];
    assign cur_pk    = i_direction ? r_pk[1]    : r_pk[0];
    assign cur_by    = i_direction ? r_by[1]    : r_by[0];
    assign cur_cnt   = i_direction ? r_cnt[1]   : r_cnt[0];
    assign cur_ptot  = i_direction ? r_ptot[1]  : r_ptot[0];
    assign cur_btot  = i_direction ? r_btot[1]  : r_btot[0];
    assign cur_ttot  = i_direction ? r_ttot[1]  : r_ttot[0];

    // Traffic the other way since the candidate began cancels it.
    assign start_eff = (oth_last > cur_start) ? '0 : cur_start;

    assign gap_delta = i_timestamp_us - cur_last;
    assign restart   = (start_eff == '0) ||
                       ((i_timestamp_us > cur_last) &&
                        (gap_delta > TW'(i_cfg.bulk_gap_us)));

    assign minp_c = (i_cfg.bulk_min_packets < MINP_FLOOR) ? MINP_FLOOR
                                                          : i_cfg.bulk_min_packets;
    assign minp   = CW'(minp_c);

    assign pk_sum = {1'b0, cur_pk} + (CW+1)'(1);
    assign pk_new = pk_sum[CW] ? '1 : pk_sum[CW-1:0];
    assign by_sum = {1'b0, cur_by} + (BW+1)'(i_packet_length);
    assign by_new = by_sum[BW] ? '1 : by_sum[BW-1:0];

    assign hit  = (pk_new == minp);
    assign over = (pk_new > minp);

    // On promotion the whole candidate goes in, afterwards one packet at a time.
    assign ptot_add = hit ? minp : CW'(1);
    assign btot_add = hit ? by_new : BW'(i_packet_length);
    assign t_base   = hit ? start_eff : cur_last;
    assign t_delta  = i_timestamp_us - t_base;
    assign t_pos    = i_timestamp_us > t_base;

    assign cnt_sum  = {1'b0, cur_cnt} + (CW+1)'(1);
    assign cnt_new  = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];
    assign ptot_sum = {1'b0, cur_ptot} + {1'b0, ptot_add};
    assign ptot_new = ptot_sum[CW] ? '1 : ptot_sum[CW-1:0];
    assign btot_sum = {1'b0, cur_btot} + {1'b0, btot_add};
    assign btot_new = btot_sum[BW] ? '1 : btot_sum[BW-1:0];
    assign ttot_sum = {1'b0, cur_ttot} + {1'b0, t_delta};
    assign ttot_new = ttot_sum[TW] ? '1 : ttot_sum[TW-1:0];

    always_comb begin
        n_start = r_start;
        n_last  = r_last;
        n_pk    = r_pk;
        n_by    = r_by;
        n_cnt   = r_cnt;
        n_ptot  = r_ptot;
        n_btot  = r_btot;
        n_ttot  = r_ttot;
        o_res_in_bulk = 1'b0;
        if (fire) begin
            if (i_clear) begin
                for (int i = 0; i < 2; i++) begin
                    n_start[i] = '0;
                    n_last[i]  = '0;
                    n_pk[i]    = '0;
                    n_by[i]    = '0;
                    n_cnt[i]   = '0;
                    n_ptot[i]  = '0;
                    n_btot[i]  = '0;
                    n_ttot[i]  = '0;
                end
            end else begin
                n_start[i_direction] = start_eff;
                if (i_empty_pkt) begin
                    o_res_in_bulk = (start_eff != '0) && (cur_pk >= minp);
                end else if (restart) begin
                    n_start[i_direction] = i_timestamp_us;
                    n_last[i_direction]  = i_timestamp_us;
                    n_pk[i_direction]    = CW'(1);
                    n_by[i_direction]    = BW'(i_packet_length);
                end else begin
                    n_pk[i_direction]   = pk_new;
                    n_by[i_direction]   = by_new;
                    n_last[i_direction] = i_timestamp_us;
                    if (hit) begin
                        n_cnt[i_direction] = cnt_new;
                    end
                    if (hit || over) begin
                        n_ptot[i_direction] = ptot_new;
                        n_btot[i_direction] = btot_new;
                        if (t_pos) begin
                            n_ttot[i_direction] = ttot_new;
                        end
                    end
                    o_res_in_bulk = (pk_new >= minp);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_start[i] <= '0;
                r_last[i]  <= '0;
                r_pk[i]    <= '0;
                r_by[i]    <= '0;
                r_cnt[i]   <= '0;
                r_ptot[i]  <= '0;
                r_btot[i]  <= '0;
                r_ttot[i]  <= '0;
            end
        end else begin
            r_start <= n_start;
            r_last  <= n_last;
            r_pk    <= n_pk;
            r_by    <= n_by;
            r_cnt   <= n_cnt;
            r_ptot  <= n_ptot;
            r_btot  <= n_btot;
            r_ttot  <= n_ttot;
        end
    end

    assign o_res_count   = n_cnt;
    assign o_res_packets = n_ptot;
    assign o_res_bytes   = n_btot;
    assign o_res_time_us = n_ttot;

    `FBTD_ASSERT_NEXT(a_clear_zeroes, fire && i_clear,
        (r_cnt[0] == '0) && (r_cnt[1] == '0) && (r_ttot[0] == '0) && (r_ttot[1] == '0),
        "clear left nonzero totals")
    `FBTD_ASSERT_NEXT(a_count_monotonic, fire && !i_clear,
        (r_cnt[0] >= $past(r_cnt[0])) && (r_cnt[1] >= $past(r_cnt[1])),
        "bulk count went down without a clear")
    `FBTD_ASSERT_SAME(a_restart_not_bulk, fire && !i_clear && !i_empty_pkt && restart,
        !o_res_in_bulk, "fresh candidate reported as bulk")
    `FBTD_ASSERT_SAME(a_no_push_when_full, o_push, !i_out_full,
        "result pushed into a full queue")

endmodule

// ----- src/fbtd_out_queue.sv -----
// ---------------------------------------------------------------------------
// fbtd_out_queue
// Result queue: holds finished results until the consumer pops them.
// ---------------------------------------------------------------------------
module fbtd_out_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    import fbtd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

// ----- src/flow_bulk_transfer_detector.sv -----
// Items are registered in the input queue and results in the result queue.
// Throughput: one item per cycle while the result queue has room; the engine's
//   per-direction state update is a read-modify-write, with two-entry queues on both sides.
// Reset (synchronous, active low): clears all candidate and total state and
//   both queues, and loads bulk_gap_us = 1000000 and bulk_min_packets = 4.
// ---------------------------------------------------------------------------
// flow_bulk_transfer_detector
// Finds bulk transfers in one two-way flow and reports per-direction totals.
// ---------------------------------------------------------------------------
module flow_bulk_transfer_detector #(
    parameter int TIME_WIDTH  = fbtd_pkg::DEF_TIME_WIDTH,
    parameter int COUNT_WIDTH = fbtd_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fbtd_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [fbtd_pkg::GAP_WIDTH-1:0]      i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_opcode,
    input  logic                                i_direction,
    input  logic [TIME_WIDTH-1:0]               i_timestamp_us,
    input  logic [fbtd_pkg::LEN_WIDTH-1:0]      i_packet_length,
    output logic                                empty,
    input  logic                                pop,
    output logic [COUNT_WIDTH-1:0]              o_fwd_bulk_count,
    output logic [COUNT_WIDTH-1:0]              o_fwd_bulk_packets,
    output logic [fbtd_pkg::BYTE_WIDTH-1:0]     o_fwd_bulk_bytes,
    output logic [TIME_WIDTH-1:0]               o_fwd_bulk_time_us,
    output logic [COUNT_WIDTH-1:0]              o_bwd_bulk_count,
    output logic [COUNT_WIDTH-1:0]              o_bwd_bulk_packets,
    output logic [fbtd_pkg::BYTE_WIDTH-1:0]     o_bwd_bulk_bytes,
    output logic [TIME_WIDTH-1:0]               o_bwd_bulk_time_us,
    output logic                                o_in_bulk
);
    import fbtd_pkg::*;

    localparam int RES_W = 2 * (2 * COUNT_WIDTH + BYTE_WIDTH + TIME_WIDTH) + 1;

    t_cfg r_cfg;

    logic                   f_valid, f_clear, f_empty_pkt, f_dir, take;
    logic [TIME_WIDTH-1:0]  f_ts;
    logic [LEN_WIDTH-1:0]   f_len;
    logic                   e_push, q_full;
    logic [COUNT_WIDTH-1:0] res_count   [2];
    logic [COUNT_WIDTH-1:0] res_packets [2];
    logic [BYTE_WIDTH-1:0]  res_bytes   [2];
    logic [TIME_WIDTH-1:0]  res_time    [2];
    logic                   res_in_bulk;
    logic [RES_W-1:0]       q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bulk_gap_us      <= GAP_RESET;
            r_cfg.bulk_min_packets <= MINP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BULK_GAP: r_cfg.bulk_gap_us      <= i_cfg_data;
                REG_BULK_MIN: r_cfg.bulk_min_packets <= i_cfg_data[MINP_WIDTH-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    fbtd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_opcode        (i_opcode),
        .i_direction     (i_direction),
        .i_timestamp_us  (i_timestamp_us),
        .i_packet_length (i_packet_length),
        .o_full          (full),
        .i_take          (take),
        .o_valid         (f_valid),
        .o_clear         (f_clear),
        .o_empty_pkt     (f_empty_pkt),
        .o_direction     (f_dir),
        .o_timestamp_us  (f_ts),
        .o_packet_length (f_len)
    );

    fbtd_engine #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (f_valid),
        .i_clear         (f_clear),
        .i_empty_pkt     (f_empty_pkt),
        .i_direction     (f_dir),
        .i_timestamp_us  (f_ts),
        .i_packet_length (f_len),
        .o_take          (take),
        .i_out_full      (q_full),
        .o_push          (e_push),
        .o_res_count     (res_count),
        .o_res_packets   (res_packets),
        .o_res_bytes     (res_bytes),
        .o_res_time_us   (res_time),
        .o_res_in_bulk   (res_in_bulk)
    );

    assign q_in = {res_count[0], res_packets[0], res_bytes[0], res_time[0],
                   res_count[1], res_packets[1], res_bytes[1], res_time[1],
                   res_in_bulk};

    fbtd_out_queue #(
        .DATA_W (RES_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (e_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign {o_fwd_bulk_count, o_fwd_bulk_packets, o_fwd_bulk_bytes, o_fwd_bulk_time_us,
            o_bwd_bulk_count, o_bwd_bulk_packets, o_bwd_bulk_bytes, o_bwd_bulk_time_us,
            o_in_bulk} = q_out;

endmodule

// ----- tb/flow_bulk_transfer_detector_checker.sv -----
// ---------------------------------------------------------------------------
// flow_bulk_transfer_detector_checker
// Watches the packet, result and register ports of the bulk transfer
// detector, predicts the per-direction bulk totals of every accepted packet
// item and compares each popped result with the oldest prediction.
// ---------------------------------------------------------------------------
module flow_bulk_transfer_detector_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fbtd_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  logic [fbtd_pkg::GAP_WIDTH-1:0]         i_cfg_data,
    input  logic                                   i_push,
    input  logic                                   i_full,
    input  logic                                   i_opcode,
    input  logic                                   i_direction,
    input  logic [fbtd_pkg::DEF_TIME_WIDTH-1:0]    i_timestamp_us,
    input  logic [fbtd_pkg::LEN_WIDTH-1:0]         i_packet_length,
    input  logic                                   i_empty,
    input  logic                                   i_pop,
    input  logic [fbtd_pkg::DEF_COUNT_WIDTH-1:0]   i_fwd_bulk_count,
    input  logic [fbtd_pkg::DEF_COUNT_WIDTH-1:0]   i_fwd_bulk_packets,
    input  logic [fbtd_pkg::BYTE_WIDTH-1:0]        i_fwd_bulk_bytes,
    input  logic [fbtd_pkg::DEF_TIME_WIDTH-1:0]    i_fwd_bulk_time_us,
    input  logic [fbtd_pkg::DEF_COUNT_WIDTH-1:0]   i_bwd_bulk_count,
    input  logic [fbtd_pkg::DEF_COUNT_WIDTH-1:0]   i_bwd_bulk_packets,
    input  logic [fbtd_pkg::BYTE_WIDTH-1:0]        i_bwd_bulk_bytes,
    input  logic [fbtd_pkg::DEF_TIME_WIDTH-1:0]    i_bwd_bulk_time_us,
    input  logic                                   i_in_bulk,
    output int                                     o_error_count,
    output int                                     o_outstanding,
    output int                                     o_results_checked,
    output int                                     o_in_bulk_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbtd_pkg::*;

    localparam int TW = DEF_TIME_WIDTH;
    localparam int CW = DEF_COUNT_WIDTH;
    localparam int BW = BYTE_WIDTH;

    typedef struct {
        bit [CW-1:0] count   [2];
        bit [CW-1:0] packets [2];
        bit [BW-1:0] bytes   [2];
        bit [TW-1:0] time_us [2];
        bit          in_bulk;
    } t_flow_totals;

    // per-direction candidate and totals, index 0 forward, 1 backward
    bit [TW-1:0]        cand_start  [2];
    bit [TW-1:0]        cand_last   [2];
    bit [CW-1:0]        cand_pkts   [2];
    bit [BW-1:0]        cand_bytes  [2];
    bit [CW-1:0]        bulks_seen  [2];
    bit [CW-1:0]        bulk_pkts   [2];
    bit [BW-1:0]        bulk_bytes  [2];
    bit [TW-1:0]        bulk_time   [2];
    bit [GAP_WIDTH-1:0] gap_us;
    bit [MINP_WIDTH-1:0] min_pkts;

    t_flow_totals pending_totals[$];
    t_flow_totals oldest;
    int           error_count;
    int           checked_count;
    int           in_bulk_count;

    function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b, int w);
        bit [63:0] lim;
        lim = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        if (a > lim) a = lim;
        if (b > lim - a) return lim;
        return a + b;
    endfunction

    function automatic bit [CW-1:0] bulk_threshold();
        return (min_pkts < MINP_FLOOR) ? CW'(MINP_FLOOR) : CW'(min_pkts);
    endfunction

    function automatic void clear_flow();
        for (int i = 0; i < 2; i++) begin
            cand_start[i] = '0;
            cand_last[i]  = '0;
            cand_pkts[i]  = '0;
            cand_bytes[i] = '0;
            bulks_seen[i] = '0;
            bulk_pkts[i]  = '0;
            bulk_bytes[i] = '0;
            bulk_time[i]  = '0;
        end
    endfunction

    function automatic void track_packet(bit d, bit [TW-1:0] ts, bit [LEN_WIDTH-1:0] len);
        bit          o;
        bit [CW-1:0] minp;
        o    = ~d;
        minp = bulk_threshold();
        // traffic the other way since this candidate began cancels it
        if (cand_last[o] > cand_start[d]) cand_start[d] = '0;
        if (len == 0) return;
        if (cand_start[d] == 0 || (ts > cand_last[d] && ts - cand_last[d] > gap_us)) begin
            cand_start[d] = ts;
            cand_last[d]  = ts;
            cand_pkts[d]  = 1;
            cand_bytes[d] = BW'(len);
            return;
        end
        cand_pkts[d]  = CW'(sat_sum(cand_pkts[d], 1, CW));
        cand_bytes[d] = BW'(sat_sum(cand_bytes[d], len, BW));
        if (cand_pkts[d] == minp) begin
            bulks_seen[d] = CW'(sat_sum(bulks_seen[d], 1, CW));
            bulk_pkts[d]  = CW'(sat_sum(bulk_pkts[d], cand_pkts[d], CW));
            bulk_bytes[d] = BW'(sat_sum(bulk_bytes[d], cand_bytes[d], BW));
            if (ts > cand_start[d])
                bulk_time[d] = TW'(sat_sum(bulk_time[d], ts - cand_start[d], TW));
        end else if (cand_pkts[d] > minp) begin
            bulk_pkts[d]  = CW'(sat_sum(bulk_pkts[d], 1, CW));
            bulk_bytes[d] = BW'(sat_sum(bulk_bytes[d], len, BW));
            if (ts > cand_last[d])
                bulk_time[d] = TW'(sat_sum(bulk_time[d], ts - cand_last[d], TW));
        end
        cand_last[d] = ts;
    endfunction

    function automatic t_flow_totals predict_totals(t_opcode op, bit d, bit [TW-1:0] ts,
                                                    bit [LEN_WIDTH-1:0] len);
        t_flow_totals t;
        t.in_bulk = 1'b0;
        if (op == OP_CLEAR) begin
            clear_flow();
        end else begin
            track_packet(d, ts, len);
            t.in_bulk = (cand_start[d] != 0) && (cand_pkts[d] >= bulk_threshold());
        end
        for (int i = 0; i < 2; i++) begin
            t.count[i]   = bulks_seen[i];
            t.packets[i] = bulk_pkts[i];
            t.bytes[i]   = bulk_bytes[i];
            t.time_us[i] = bulk_time[i];
        end
        return t;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_flow();
            gap_us   = GAP_RESET;
            min_pkts = MINP_RESET;
            pending_totals.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_totals.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    error_count++;
                end else begin
                    oldest = pending_totals.pop_front();
                    check_field("fwd_bulk_count",   oldest.count[0],   i_fwd_bulk_count);
                    check_field("fwd_bulk_packets", oldest.packets[0], i_fwd_bulk_packets);
                    check_field("fwd_bulk_bytes",   oldest.bytes[0],   i_fwd_bulk_bytes);
                    check_field("fwd_bulk_time_us", oldest.time_us[0], i_fwd_bulk_time_us);
                    check_field("bwd_bulk_count",   oldest.count[1],   i_bwd_bulk_count);
                    check_field("bwd_bulk_packets", oldest.packets[1], i_bwd_bulk_packets);
                    check_field("bwd_bulk_bytes",   oldest.bytes[1],   i_bwd_bulk_bytes);
                    check_field("bwd_bulk_time_us", oldest.time_us[1], i_bwd_bulk_time_us);
                    check_field("in_bulk",          oldest.in_bulk,    i_in_bulk);
                    checked_count++;
                    if (oldest.in_bulk) in_bulk_count++;
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_BULK_GAP: gap_us   = i_cfg_data;
                    REG_BULK_MIN: min_pkts = i_cfg_data[MINP_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                pending_totals.push_back(predict_totals(t_opcode'(i_opcode), i_direction,
                                                        i_timestamp_us, i_packet_length));
            end
        end
        o_error_count     <= error_count;
        o_outstanding     <= pending_totals.size();
        o_results_checked <= checked_count;
        o_in_bulk_results <= in_bulk_count;
    end

endmodule

// ----- tb/flow_bulk_transfer_detector_test.sv -----
// ---------------------------------------------------------------------------
// flow_bulk_transfer_detector_test
// Drives packet items into the bulk transfer detector through its push/full
// port and drains results through empty/pop: a short directed sequence, then
// random bulk runs with cancels, gaps and clears over several register
// settings, with random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module flow_bulk_transfer_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbtd_pkg::*;

    localparam int TW          = DEF_TIME_WIDTH;
    localparam int CW          = DEF_COUNT_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index     = '0;
    logic [GAP_WIDTH-1:0]     cfg_data      = '0;
    logic                     push          = 1'b0;
    logic                     full;
    logic                     opcode        = 1'b0;
    logic                     direction     = 1'b0;
    logic [TW-1:0]            timestamp_us  = '0;
    logic [LEN_WIDTH-1:0]     packet_length = '0;
    logic                     empty;
    logic                     pop           = 1'b0;
    logic [CW-1:0]            fwd_bulk_count, fwd_bulk_packets;
    logic [BYTE_WIDTH-1:0]    fwd_bulk_bytes;
    logic [TW-1:0]            fwd_bulk_time_us;
    logic [CW-1:0]            bwd_bulk_count, bwd_bulk_packets;
    logic [BYTE_WIDTH-1:0]    bwd_bulk_bytes;
    logic [TW-1:0]            bwd_bulk_time_us;
    logic                     in_bulk;

    int error_count;
    int outstanding;
    int results_checked;
    int in_bulk_results;

    int           cycle_count    = 0;
    int           items_sent     = 0;
    int           clears_sent    = 0;
    int           settings_used  = 0;
    int           burst_left     = 0;
    bit           long_hold_req  = 1'b0;
    bit [31:0]    cur_gap        = GAP_RESET;
    int           cur_min        = MINP_RESET;
    bit [TW-1:0]  clock_us       = '0;

    flow_bulk_transfer_detector u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .push               (push),
        .full               (full),
        .i_opcode           (opcode),
        .i_direction        (direction),
        .i_timestamp_us     (timestamp_us),
        .i_packet_length    (packet_length),
        .empty              (empty),
        .pop                (pop),
        .o_fwd_bulk_count   (fwd_bulk_count),
        .o_fwd_bulk_packets (fwd_bulk_packets),
        .o_fwd_bulk_bytes   (fwd_bulk_bytes),
        .o_fwd_bulk_time_us (fwd_bulk_time_us),
        .o_bwd_bulk_count   (bwd_bulk_count),
        .o_bwd_bulk_packets (bwd_bulk_packets),
        .o_bwd_bulk_bytes   (bwd_bulk_bytes),
        .o_bwd_bulk_time_us (bwd_bulk_time_us),
        .o_in_bulk          (in_bulk)
    );

    flow_bulk_transfer_detector_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_push             (push),
        .i_full             (full),
        .i_opcode           (opcode),
        .i_direction        (direction),
        .i_timestamp_us     (timestamp_us),
        .i_packet_length    (packet_length),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_fwd_bulk_count   (fwd_bulk_count),
        .i_fwd_bulk_packets (fwd_bulk_packets),
        .i_fwd_bulk_bytes   (fwd_bulk_bytes),
        .i_fwd_bulk_time_us (fwd_bulk_time_us),
        .i_bwd_bulk_count   (bwd_bulk_count),
        .i_bwd_bulk_packets (bwd_bulk_packets),
        .i_bwd_bulk_bytes   (bwd_bulk_bytes),
        .i_bwd_bulk_time_us (bwd_bulk_time_us),
        .i_in_bulk          (in_bulk),
        .o_error_count      (error_count),
        .o_outstanding      (outstanding),
        .o_results_checked  (results_checked),
        .o_in_bulk_results  (in_bulk_results)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: stall pattern changes every stretch; a long hold-off on request
    initial begin : result_drain
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(posedge clk);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 0);
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic bit [TW-1:0] rand_ts();
        bit [63:0] w;
        w = {$urandom, $urandom};
        return w[TW-1:0];
    endfunction

    function automatic bit [LEN_WIDTH-1:0] rand_len();
        if ($urandom_range(0, 9) == 0) return '1;
        return LEN_WIDTH'($urandom_range(1, 65535));
    endfunction

    // time advance that stays inside the configured gap, but a zero gap is sometimes stepped by one
    function automatic bit [TW-1:0] next_step();
        if (cur_gap == 0) return ($urandom_range(0, 4) == 0) ? TW'(1) : '0;
        return TW'($urandom_range(0, (cur_gap > 500) ? 500 : cur_gap));
    endfunction

    task automatic push_item(t_opcode op, bit dir, bit [TW-1:0] ts, bit [LEN_WIDTH-1:0] len);
        int pause;
        if (burst_left == 0) begin
            pause = $urandom_range(0, 6);
            if (pause != 0) begin
                push <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push          <= 1'b1;
        opcode        <= op;
        direction     <= dir;
        timestamp_us  <= ts;
        packet_length <= len;
        do @(posedge clk); while (full);
        items_sent++;
        if (op == OP_CLEAR) clears_sent++;
    endtask

    task automatic write_config(bit [31:0] gap, bit [MINP_WIDTH-1:0] minp);
        bit [31:0] data;
        data = $urandom;
        data[MINP_WIDTH-1:0] = minp;
        cfg_we    <= 1'b1;
        cfg_index <= REG_BULK_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= REG_BULK_MIN;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_gap = gap;
        cur_min = int'((minp < MINP_FLOOR) ? MINP_FLOOR : minp);
        settings_used++;
    endtask

    // stop offering and wait for every prediction to be matched
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // one direction's run of packets; unless clean, mix in cancels, empties,
    // backward time, gap edges, clears and zero timestamps
    task automatic send_bulk_run(bit dir, int n, bit clean);
        int r;
        repeat (n) begin
            r = clean ? 99 : $urandom_range(0, 99);
            if (r < 6) begin
                push_item(OP_UPDATE, !dir, clock_us, rand_len());
            end else if (r < 10) begin
                push_item(OP_UPDATE, dir, clock_us + next_step(), '0);
            end else if (r < 13) begin
                push_item(OP_UPDATE, dir, clock_us - TW'($urandom_range(1, 100)), rand_len());
            end else if (r < 15) begin
                clock_us += TW'(cur_gap) + 1;
                push_item(OP_UPDATE, dir, clock_us, rand_len());
            end else if (r < 17) begin
                clock_us += TW'(cur_gap);
                push_item(OP_UPDATE, dir, clock_us, rand_len());
            end else if (r < 18) begin
                push_item(OP_CLEAR, 1'($urandom_range(0, 1)), rand_ts(), LEN_WIDTH'($urandom));
            end else if (r < 19) begin
                push_item(OP_UPDATE, dir, '0, rand_len());
            end else begin
                clock_us += next_step();
                push_item(OP_UPDATE, dir, clock_us, rand_len());
            end
        end
    endtask

    task automatic run_phase(bit [31:0] gap, bit [MINP_WIDTH-1:0] minp, int target,
                             bit long_run, bit pressure);
        int      stop_at;
        t_opcode op;
        write_config(gap, minp);
        stop_at = items_sent + target;
        long_hold_req = pressure;
        if (long_run) send_bulk_run(1'($urandom_range(0, 1)), cur_min + 3, 1'b1);
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_UPDATE;
                push_item(op, 1'($urandom_range(0, 1)), rand_ts(),
                          ($urandom_range(0, 4) == 0) ? '0 : LEN_WIDTH'($urandom));
            end else begin
                if ($urandom_range(0, 19) == 0) clock_us = rand_ts();
                send_bulk_run(1'($urandom_range(0, 1)), int'($urandom_range(1, cur_min + 3)),
                              1'b0);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: gap 1000000 us, four packets to a bulk
        push_item(OP_CLEAR,  1'b1, '1, '1);
        push_item(OP_UPDATE, 1'b0, 100, 1);
        push_item(OP_UPDATE, 1'b0, 150, '1);
        push_item(OP_UPDATE, 1'b0, 200, 10);
        push_item(OP_UPDATE, 1'b0, 250, 20);
        push_item(OP_UPDATE, 1'b0, 260, 0);
        push_item(OP_UPDATE, 1'b0, 270, 30);
        push_item(OP_UPDATE, 1'b1, 310, 5);
        push_item(OP_UPDATE, 1'b0, 320, 8);
        push_item(OP_UPDATE, 1'b0, 300, 7);
        push_item(OP_UPDATE, 1'b0, 1000300, 3);
        push_item(OP_UPDATE, 1'b0, 2000301, 4);
        for (int i = 3; i >= 0; i--)
            push_item(OP_UPDATE, 1'b1, '1 - TW'(i), '1);
        push_item(OP_CLEAR,  1'b0, '0, '0);
        push_item(OP_UPDATE, 1'b0, 0, 5);
        push_item(OP_UPDATE, 1'b0, 10, 5);
        push_item(OP_UPDATE, 1'b0, 20, 5);
        drain();

        clock_us = 48'd1000;
        run_phase(100, 2, 150, 1'b0, 1'b0);
        run_phase(0, 0, 100, 1'b0, 1'b0);
        run_phase(1, 1, 100, 1'b0, 1'b0);
        run_phase('1, 8'hFF, 60, 1'b1, 1'b0);
        run_phase(32'($urandom_range(1, 5000)), MINP_WIDTH'($urandom_range(3, 10)), 200,
                  1'b0, 1'b1);

        $display("Covered %0d packet items (%0d clears) over %0d register settings.",
                 items_sent, clears_sent, settings_used + 1);
        $display("Compared %0d results, %0d of them reporting an open bulk.",
                 results_checked, in_bulk_results);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
